// ===== rtl/core/mec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mec_pkg
// Types, constants and arithmetic helpers for the escape-time counter.
// ----------------------------------------------------------------------------
package mec_pkg;

    localparam int DATA_W    = 32;
    localparam int ACC_W     = 2 * DATA_W;
    localparam int FRAC_BITS = 28;
    localparam int NUM_CELLS = 2;
    localparam int SLICE_W   = DATA_W / NUM_CELLS;
    localparam int PROD_W    = DATA_W + SLICE_W + 1;
    localparam int COORD_W   = 10;
    localparam int LIMIT_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int MAP_W     = DATA_W + COORD_W + 1;
    localparam int MAPSUM_W  = MAP_W + 1;

    localparam int  RADIUS_SHIFT  = 2 * FRAC_BITS + 2;
    localparam bit  RADIUS_ALWAYS = (RADIUS_SHIFT >= ACC_W);
    localparam logic [ACC_W-1:0] RADIUS_SQ =
        RADIUS_ALWAYS ? '1 : (ACC_W'(1) << (RADIUS_ALWAYS ? 0 : RADIUS_SHIFT));

    localparam logic signed [DATA_W-1:0] ORIGIN_RE_RST = 32'shD000_0000;
    localparam logic signed [DATA_W-1:0] ORIGIN_IM_RST = 32'shEE00_0000;
    localparam logic signed [DATA_W-1:0] STEP_RE_RST   = 32'sd786432;
    localparam logic signed [DATA_W-1:0] STEP_IM_RST   = 32'sd589824;
    localparam logic [LIMIT_W-1:0]       LIMIT_RST     = 16'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_RE = 3'd0,
        CFG_ORIGIN_IM = 3'd1,
        CFG_STEP_RE   = 3'd2,
        CFG_STEP_IM   = 3'd3,
        CFG_LIMIT     = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAP0,
        S_MAP1,
        S_ITER
    } t_state;

    typedef struct packed {
        logic                     valid;
        logic                     hi_signed;
        logic signed [DATA_W-1:0] a_re;
        logic signed [DATA_W-1:0] a_im;
        logic [DATA_W-1:0]        b_re;
        logic [DATA_W-1:0]        b_im;
        logic signed [ACC_W-1:0]  acc_rr;
        logic signed [ACC_W-1:0]  acc_ii;
        logic signed [ACC_W-1:0]  acc_ri;
    } t_cell_bus;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] max_v;
        logic signed [ACC_W-1:0] min_v;
        max_v = ACC_W'({1'b0, {(DATA_W-1){1'b1}}});
        min_v = -max_v - ACC_W'(1);
        if (v > max_v) begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end else if (v < min_v) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end
        return v[DATA_W-1:0];
    endfunction

endpackage

// ===== rtl/core/mec_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mec_cell
// One slice of the squaring chain: adds three partial products per cycle.
// ----------------------------------------------------------------------------
module mec_cell import mec_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_bus i_bus,
    output t_cell_bus o_bus
);

    t_cell_bus r_bus;
    logic signed [SLICE_W:0]   w_sl_re;
    logic signed [SLICE_W:0]   w_sl_im;
    logic signed [PROD_W-1:0]  w_p_rr;
    logic signed [PROD_W-1:0]  w_p_ii;
    logic signed [PROD_W-1:0]  w_p_ri;
    t_cell_bus n_bus;

    always_comb begin
        w_sl_re = {i_bus.b_re[DATA_W-1] & i_bus.hi_signed, i_bus.b_re[DATA_W-1 -: SLICE_W]};
        w_sl_im = {i_bus.b_im[DATA_W-1] & i_bus.hi_signed, i_bus.b_im[DATA_W-1 -: SLICE_W]};
        w_p_rr  = i_bus.a_re * w_sl_re;
        w_p_ii  = i_bus.a_im * w_sl_im;
        w_p_ri  = i_bus.a_re * w_sl_im;
        n_bus           = i_bus;
        n_bus.hi_signed = 1'b0;
        n_bus.b_re      = i_bus.b_re << SLICE_W;
        n_bus.b_im      = i_bus.b_im << SLICE_W;
        n_bus.acc_rr    = (i_bus.acc_rr <<< SLICE_W) + ACC_W'(w_p_rr);
        n_bus.acc_ii    = (i_bus.acc_ii <<< SLICE_W) + ACC_W'(w_p_ii);
        n_bus.acc_ri    = (i_bus.acc_ri <<< SLICE_W) + ACC_W'(w_p_ri);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else begin
            r_bus.valid <= i_bus.valid;
        end
        r_bus.hi_signed <= n_bus.hi_signed;
        r_bus.a_re      <= n_bus.a_re;
        r_bus.a_im      <= n_bus.a_im;
        r_bus.b_re      <= n_bus.b_re;
        r_bus.b_im      <= n_bus.b_im;
        r_bus.acc_rr    <= n_bus.acc_rr;
        r_bus.acc_ii    <= n_bus.acc_ii;
        r_bus.acc_ri    <= n_bus.acc_ri;
    end

    assign o_bus = r_bus;

endmodule

// ===== rtl/core/mandelbrot_escape_counter_top.sv =====
`timescale 1ns / 1ps
// After a pixel is accepted, S_MAP0 maps it to c and S_MAP1 clears z and launches the chain;
// each iteration passes through two chain cells and one update, and the result strobe is registered.
// Throughput: one pixel at a time; busy falls with the strobe, so the next pixel is not taken
// while the previous one is in flight. The receiver cannot stall.
// Reset is synchronous and active low; it restores the default view and a limit of 256.
// ----------------------------------------------------------------------------
// mandelbrot_escape_counter_top
// Maps a pixel to c and counts Mandelbrot iterations until escape or limit.
// ----------------------------------------------------------------------------
module mandelbrot_escape_counter_top import mec_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [COORD_W-1:0]   i_column,
    input  logic [COORD_W-1:0]   i_row,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0]    i_cfg_data,
    output logic                 o_valid,
    output logic [LIMIT_W-1:0]   o_iteration_count,
    output logic                 o_inside_set
);

    t_state r_state, n_state;
    logic signed [DATA_W-1:0] r_origin_re, r_origin_im, r_step_re, r_step_im;
    logic [LIMIT_W-1:0]       r_limit;
    logic signed [MAP_W-1:0]  r_prod_re, n_prod_re, r_prod_im, n_prod_im;
    logic signed [DATA_W-1:0] r_c_re, n_c_re, r_c_im, n_c_im;
    logic signed [DATA_W-1:0] r_z_re, n_z_re, r_z_im, n_z_im;
    logic [LIMIT_W-1:0]       r_count, n_count;
    logic                     r_launch, n_launch;
    logic                     r_valid, n_valid;
    logic [LIMIT_W-1:0]       r_out_count, n_out_count;
    logic                     r_out_inside, n_out_inside;

    t_cell_bus w_bus [NUM_CELLS+1];
    logic [NUM_CELLS:0] w_valids;
    logic [ACC_W-1:0]        w_mag;
    logic                    w_within;
    logic signed [ACC_W-1:0] w_diff;
    logic signed [ACC_W-1:0] w_new_re;
    logic signed [ACC_W-1:0] w_new_im;

    always_comb begin
        w_bus[0].valid     = r_launch;
        w_bus[0].hi_signed = 1'b1;
        w_bus[0].a_re      = r_z_re;
        w_bus[0].a_im      = r_z_im;
        w_bus[0].b_re      = r_z_re;
        w_bus[0].b_im      = r_z_im;
        w_bus[0].acc_rr    = '0;
        w_bus[0].acc_ii    = '0;
        w_bus[0].acc_ri    = '0;
    end

    genvar g;
    generate
        for (g = 0; g < NUM_CELLS; g++) begin : g_cell
            mec_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_bus   (w_bus[g]),
                .o_bus   (w_bus[g+1])
            );
        end
        for (g = 0; g <= NUM_CELLS; g++) begin : g_vld
            assign w_valids[g] = w_bus[g].valid;
        end
    endgenerate

    always_comb begin
        w_mag    = $unsigned(w_bus[NUM_CELLS].acc_rr) + $unsigned(w_bus[NUM_CELLS].acc_ii);
        w_within = RADIUS_ALWAYS || (w_mag <= RADIUS_SQ);
        w_diff   = w_bus[NUM_CELLS].acc_rr - w_bus[NUM_CELLS].acc_ii;
        w_new_re = (w_diff >>> FRAC_BITS) + ACC_W'(r_c_re);
        w_new_im = (w_bus[NUM_CELLS].acc_ri >>> (FRAC_BITS - 1)) + ACC_W'(r_c_im);
    end

    always_comb begin
        n_state      = r_state;
        n_prod_re    = r_prod_re;
        n_prod_im    = r_prod_im;
        n_c_re       = r_c_re;
        n_c_im       = r_c_im;
        n_z_re       = r_z_re;
        n_z_im       = r_z_im;
        n_count      = r_count;
        n_launch     = 1'b0;
        n_valid      = 1'b0;
        n_out_count  = r_out_count;
        n_out_inside = r_out_inside;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_prod_re = $signed({1'b0, i_column}) * r_step_re;
                    n_prod_im = $signed({1'b0, i_row}) * r_step_im;
                    n_state   = S_MAP0;
                end
            end
            S_MAP0: begin
                n_c_re  = sat32(ACC_W'(MAPSUM_W'(r_origin_re) + MAPSUM_W'(r_prod_re)));
                n_c_im  = sat32(ACC_W'(MAPSUM_W'(r_origin_im) + MAPSUM_W'(r_prod_im)));
                n_state = S_MAP1;
            end
            S_MAP1: begin
                n_z_re   = '0;
                n_z_im   = '0;
                n_count  = '0;
                n_launch = 1'b1;
                n_state  = S_ITER;
            end
            S_ITER: begin
                if (w_bus[NUM_CELLS].valid) begin
                    if ((r_count < r_limit) && w_within) begin
                        n_z_re   = sat32(w_new_re);
                        n_z_im   = sat32(w_new_im);
                        n_count  = r_count + LIMIT_W'(1);
                        n_launch = 1'b1;
                    end else begin
                        n_out_count  = r_count;
                        n_out_inside = (r_count == r_limit);
                        n_valid      = 1'b1;
                        n_state      = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_launch    <= 1'b0;
            r_valid     <= 1'b0;
            r_origin_re <= ORIGIN_RE_RST;
            r_origin_im <= ORIGIN_IM_RST;
            r_step_re   <= STEP_RE_RST;
            r_step_im   <= STEP_IM_RST;
            r_limit     <= LIMIT_RST;
        end else begin
            r_state  <= n_state;
            r_launch <= n_launch;
            r_valid  <= n_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ORIGIN_RE: r_origin_re <= i_cfg_data;
                    CFG_ORIGIN_IM: r_origin_im <= i_cfg_data;
                    CFG_STEP_RE:   r_step_re   <= i_cfg_data;
                    CFG_STEP_IM:   r_step_im   <= i_cfg_data;
                    CFG_LIMIT:     r_limit     <= i_cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
        end
        r_prod_re    <= n_prod_re;
        r_prod_im    <= n_prod_im;
        r_c_re       <= n_c_re;
        r_c_im       <= n_c_im;
        r_z_re       <= n_z_re;
        r_z_im       <= n_z_im;
        r_count      <= n_count;
        r_out_count  <= n_out_count;
        r_out_inside <= n_out_inside;
    end

    assign busy              = (r_state != S_IDLE);
    assign o_valid           = r_valid;
    assign o_iteration_count = r_out_count;
    assign o_inside_set      = r_out_inside;

`ifndef NO_ASSERTIONS
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_valids))
        else $error("More than one iteration in the squaring chain.");
    a_chain_in_iter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bus[NUM_CELLS].valid |-> r_state == S_ITER)
        else $error("Chain output outside the iteration phase.");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted transaction did not raise busy.");
    a_inside_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_inside_set) |-> o_iteration_count == r_limit)
        else $error("Inside flag without reaching the limit.");
`endif

endmodule

// ===== tb/mandelbrot_escape_counter_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_counter_top_tb
// Self-checking testbench for the Mandelbrot escape-time counter. A local
// fixed-point model predicts the iteration count and inside flag of every
// accepted pixel, and a monitor compares each result strobe against the
// oldest prediction. Directed tests cover reset defaults, limit extremes,
// saturation, wide and unknown register writes; random phases follow.
// ----------------------------------------------------------------------------
module mandelbrot_escape_counter_top_tb;
    import mec_pkg::*;

    localparam int WATCHDOG_CYCLES = 1000000;
    localparam int RANDOM_PHASES = 33;
    localparam int ITEMS_PER_PHASE = 50;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNUSED = 3'd7;

    typedef struct {
        logic [LIMIT_W-1:0] count;
        logic               in_set;
    } escape_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [COORD_W-1:0]   i_column = '0;
    logic [COORD_W-1:0]   i_row = '0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [DATA_W-1:0]    i_cfg_data = '0;
    logic                 o_valid;
    logic [LIMIT_W-1:0]   o_iteration_count;
    logic                 o_inside_set;

    logic signed [DATA_W-1:0] view_origin_re = ORIGIN_RE_RST;
    logic signed [DATA_W-1:0] view_origin_im = ORIGIN_IM_RST;
    logic signed [DATA_W-1:0] view_step_re = STEP_RE_RST;
    logic signed [DATA_W-1:0] view_step_im = STEP_IM_RST;
    logic [LIMIT_W-1:0]       view_limit = LIMIT_RST;

    escape_t pending_escapes[$];
    int      error_count = 0;
    int      pixels_sent = 0;
    int      results_seen = 0;
    int      idle_cycles = 0;

    mandelbrot_escape_counter_top i_dut (.*);

    always #4 i_clk = ~i_clk;

    function automatic longint clip32(input longint v);
        if (v > longint'(32'sh7FFF_FFFF)) return longint'(32'sh7FFF_FFFF);
        if (v < -longint'(32'sh7FFF_FFFF) - 1) return -longint'(32'sh7FFF_FFFF) - 1;
        return v;
    endfunction

    function automatic escape_t predict_escape(input logic [COORD_W-1:0] col,
                                               input logic [COORD_W-1:0] row);
        longint          c_re;
        longint          c_im;
        longint          z_re;
        longint          z_im;
        longint          next_re;
        longint          next_im;
        longint unsigned mag_sq;
        longint unsigned radius_sq;
        int unsigned     n;
        escape_t         r;
        radius_sq = 64'd1 << (2 * FRAC_BITS + 2);
        c_re = clip32(longint'(view_origin_re) + longint'(col) * longint'(view_step_re));
        c_im = clip32(longint'(view_origin_im) + longint'(row) * longint'(view_step_im));
        z_re = 0;
        z_im = 0;
        n = 0;
        while (n < view_limit) begin
            mag_sq = longint'(z_re * z_re) + longint'(z_im * z_im);
            if (mag_sq > radius_sq) break;
            next_re = clip32(((z_re * z_re - z_im * z_im) >>> FRAC_BITS) + c_re);
            next_im = clip32(((z_re * z_im) >>> (FRAC_BITS - 1)) + c_im);
            z_re = next_re;
            z_im = next_im;
            n++;
        end
        r.count = n[LIMIT_W-1:0];
        r.in_set = (n == view_limit);
        return r;
    endfunction

    always @(posedge i_clk) begin
        escape_t exp_r;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (pending_escapes.size() == 0) begin
                $error("Result transaction with no pending expectation");
                error_count++;
            end else begin
                exp_r = pending_escapes.pop_front();
                if (o_iteration_count !== exp_r.count) begin
                    $error("iteration_count expected %0d actual %0d",
                           exp_r.count, o_iteration_count);
                    error_count++;
                end
                if (o_inside_set !== exp_r.in_set) begin
                    $error("inside_set expected %0d actual %0d", exp_r.in_set, o_inside_set);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("FAIL mandelbrot_escape_counter_top");
                $finish;
            end
        end
    end

    task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
        int gap;
        gap = $urandom_range(0, 5);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_column <= col;
        i_row <= row;
        do @(posedge i_clk); while (busy);
        pending_escapes.push_back(predict_escape(col, row));
        pixels_sent++;
    endtask

    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_escapes.size() != 0 || busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ORIGIN_RE: view_origin_re = data;
            CFG_ORIGIN_IM: view_origin_im = data;
            CFG_STEP_RE:   view_step_re = data;
            CFG_STEP_IM:   view_step_im = data;
            CFG_LIMIT:     view_limit = data[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_view(input logic [DATA_W-1:0] ore, input logic [DATA_W-1:0] oim,
                            input logic [DATA_W-1:0] sre, input logic [DATA_W-1:0] sim,
                            input logic [DATA_W-1:0] lim);
        cfg_write(CFG_ORIGIN_RE, ore);
        cfg_write(CFG_ORIGIN_IM, oim);
        cfg_write(CFG_STEP_RE, sre);
        cfg_write(CFG_STEP_IM, sim);
        cfg_write(CFG_LIMIT, lim);
    endtask

    task automatic test_reset_defaults;
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd683, 10'd512);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        drain();
    endtask

    task automatic test_limit_extremes;
        cfg_write(CFG_LIMIT, 32'd0);
        send_pixel(10'd683, 10'd512);
        send_pixel(10'd0, 10'd0);
        drain();
        cfg_write(CFG_LIMIT, 32'd1);
        send_pixel(10'd683, 10'd512);
        send_pixel(10'd0, 10'd0);
        drain();
        cfg_write(CFG_LIMIT, 32'hABCD_0003);
        send_pixel(10'd683, 10'd512);
        send_pixel(10'd1023, 10'd1023);
        drain();
        set_view(32'd0, 32'd0, 32'd0, 32'd0, 32'd65535);
        send_pixel(10'd1023, 10'd1023);
        drain();
        cfg_write(CFG_ORIGIN_RE, 32'h2000_0000);
        send_pixel(10'd5, 10'd5);
        drain();
    endtask

    task automatic test_saturation;
        set_view(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1);
        send_pixel(10'd1023, 10'd1023);
        drain();
        set_view(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd16);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd0, 10'd0);
        drain();
        // c = -2 sits on the escape circle forever; c = 0.25 converges slowly.
        set_view(32'hE000_0000, 32'd0, 32'd0, 32'd0, 32'd40);
        send_pixel(10'd0, 10'd0);
        drain();
        cfg_write(CFG_ORIGIN_RE, 32'h0400_0000);
        send_pixel(10'd0, 10'd0);
        drain();
        cfg_write(CFG_ORIGIN_RE, 32'h1FFF_FFFF);
        cfg_write(CFG_ORIGIN_IM, 32'h1FFF_FFFF);
        send_pixel(10'd0, 10'd0);
        drain();
    endtask

    task automatic test_unknown_index;
        logic [CFG_IDX_W-1:0] idx;
        for (idx = CFG_FIRST_UNUSED; idx <= CFG_LAST_UNUSED && idx >= CFG_FIRST_UNUSED;
             idx++) begin
            cfg_write(idx, $urandom());
        end
        send_pixel(10'd300, 10'd700);
        send_pixel(10'd700, 10'd300);
        drain();
    endtask

    task automatic test_random_views;
        logic [DATA_W-1:0] ore;
        logic [DATA_W-1:0] oim;
        logic [DATA_W-1:0] sre;
        logic [DATA_W-1:0] sim;
        logic [DATA_W-1:0] lim;
        int                flavor;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            flavor = $urandom_range(0, 9);
            if (flavor == 0) begin
                ore = $urandom();
                oim = $urandom();
                sre = $urandom();
                sim = $urandom();
            end else begin
                ore = int'($urandom_range(0, 805306368)) - 671088640;
                oim = int'($urandom_range(0, 671088640)) - 335544320;
                sre = int'($urandom_range(0, 1 << 20)) - (1 << 19);
                sim = int'($urandom_range(0, 1 << 20)) - (1 << 19);
            end
            lim = {$urandom_range(0, 65535) << 16} | $urandom_range(1, 48);
            if (flavor == 1) lim[LIMIT_W-1:0] = 16'd256;
            set_view(ore, oim, sre, sim, lim);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                send_pixel(COORD_W'($urandom()), COORD_W'($urandom()));
            end
            drain();
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_limit_extremes();
        test_saturation();
        test_unknown_index();
        test_random_views();
        drain();
        $display("Covered %0d pixel transactions and %0d result transactions", pixels_sent,
                 results_seen);
        $display("over default, extreme, saturating, and random views and limits.");
        if (error_count == 0 && pending_escapes.size() == 0) begin
            $display("PASS mandelbrot_escape_counter_top");
        end else begin
            $display("FAIL mandelbrot_escape_counter_top");
        end
        $finish;
    end

endmodule
